/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the feedback delay line.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/fdl_pkg.sv */
// Shared types and constants of the feedback delay line.
// No dependencies; imported by fdl_arith and feedback_delay_line_top.
`default_nettype none

package fdl_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int DELAY_W   = 16;
   localparam int FRAC_W    = 8;
   localparam int GAIN_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_WHOLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_FRAC    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_GAIN = 2'd2;

   localparam int DELAY_WHOLE_RST = 4800;

   typedef logic [2:0] fdl_op_type;

   // datapath operations issued by the sequencer
   localparam fdl_op_type OP_NONE   = 3'd0;
   localparam fdl_op_type OP_LOAD_B = 3'd1;  // capture newer tap
   localparam fdl_op_type OP_DIFF   = 3'd2;  // older tap minus newer tap
   localparam fdl_op_type OP_MULF   = 3'd3;  // difference times fraction
   localparam fdl_op_type OP_INTERP = 3'd4;  // newer tap * 256 plus product
   localparam fdl_op_type OP_MULG   = 3'd5;  // interpolated value times gain
   localparam fdl_op_type OP_ROUND  = 3'd6;  // round off 22 fraction bits

   typedef struct packed {
      fdl_op_type op;
      logic       busy;   // a sample is in flight
   } fdl_ctl_type;

endpackage

`default_nettype wire

/* sv/fdl_arith.sv */
// Arithmetic datapath of the feedback delay line: one shared 32x17 multiplier,
// operand/product registers, rounding and output saturation. Uses fdl_pkg.
`default_nettype none

module fdl_arith (
   input  wire logic                               clock,
   input  wire fdl_pkg::fdl_ctl_type               ctl,
   input  wire logic signed [fdl_pkg::SAMPLE_W-1:0] rd_data,
   input  wire logic        [fdl_pkg::FRAC_W-1:0]   frac,
   input  wire logic signed [fdl_pkg::GAIN_W-1:0]   gain,
   input  wire logic signed [fdl_pkg::SAMPLE_W-1:0] sample,
   output logic      signed [fdl_pkg::SAMPLE_W-1:0] sum
);
   import fdl_pkg::*;

   localparam logic signed [32:0] SAT_HI = 33'sd8388607;
   localparam logic signed [32:0] SAT_LO = -33'sd8388608;
   localparam logic signed [47:0] RND_HALF = 48'sd2097152;

   logic signed [SAMPLE_W-1:0] b_ff, b_in;
   logic signed [31:0]         opa_ff, opa_in;
   logic signed [47:0]         mul_ff, mul_in;
   logic signed [16:0]         mul_b;
   logic signed [48:0]         prod;
   logic signed [47:0]         rnd_sum;
   logic signed [32:0]         wide_sum;

   // the one multiplier: fraction on the first pass, gain on the second
   always_comb begin
      if (ctl.op == OP_MULF) begin
         mul_b = $signed({9'b0, frac});
      end else begin
         mul_b = 17'(gain);
      end
   end

   assign prod    = 49'(opa_ff) * 49'(mul_b);
   assign rnd_sum = mul_ff + RND_HALF;

   always_comb begin
      b_in   = b_ff;
      opa_in = opa_ff;
      mul_in = mul_ff;
      unique case (ctl.op)
         OP_LOAD_B: begin
            b_in = rd_data;
         end
         OP_DIFF: begin
            opa_in = 32'(rd_data) - 32'(b_ff);
         end
         OP_MULF, OP_MULG: begin
            mul_in = $signed(prod[47:0]);
         end
         OP_INTERP: begin
            opa_in = $signed({b_ff, 8'h00}) + $signed(mul_ff[31:0]);
         end
         OP_ROUND: begin
            opa_in = 32'($signed(rnd_sum[47:22]));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      b_ff   <= b_in;
      opa_ff <= opa_in;
      mul_ff <= mul_in;
   end

   assign wide_sum = 33'(opa_ff) + 33'(sample);

   always_comb begin
      priority if (wide_sum > SAT_HI) begin
         sum = SAT_HI[SAMPLE_W-1:0];
      end else if (wide_sum < SAT_LO) begin
         sum = SAT_LO[SAMPLE_W-1:0];
      end else begin
         sum = wide_sum[SAMPLE_W-1:0];
      end
   end

endmodule

`default_nettype wire

/* sv/feedback_delay_line_top.sv */
// Top level of the feedback delay line (comb filter): sequencer, sample store,
// delay reduction and register file. Uses fdl_pkg, fdl_arith, assert_macros.svh.
`default_nettype none

// Each accepted sample yields one output y = sat24(x + round(g * d)), where d is
// the store read delay_whole + delay_frac/256 samples behind the write position,
// linearly interpolated, and g is the Q2.14 feedback gain; y is then written to
// the store. req_tready stays low from the acceptance of a sample until its
// result leaves S_OUT, so no new sample is taken while one is in flight: the
// store has one read port, so the two taps are read in turn (S_RDB, S_RDA), and
// one multiplier is used twice (fraction, then gain), with rounding in its own
// step and saturation in S_OUT. The output is held in a register, so a stalled
// result only holds the sequencer in S_OUT.
// After reset the store is zeroed slot by slot with req_tready low. A write of
// delay_whole is reduced modulo STORE_DEPTH by a shift-and-subtract loop
// (skipped when STORE_DEPTH exceeds 65535), also with req_tready low.
module feedback_delay_line_top #(
   parameter int STORE_DEPTH = 65536
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input samples
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic signed [fdl_pkg::SAMPLE_W-1:0] req_tdata,  // [23:0] sample_in
   // output samples
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic signed [fdl_pkg::SAMPLE_W-1:0]      rsp_tdata,  // [23:0] sample_out
   // register writes
   input  wire logic                                csr_wen,
   input  wire logic [fdl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [fdl_pkg::CSR_DAT_W-1:0]       csr_wdata
);
   import fdl_pkg::*;

`include "assert_macros.svh"

   localparam int AW = $clog2(STORE_DEPTH);
   localparam logic [AW:0]   DEPTH_X = (AW+1)'(STORE_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(STORE_DEPTH - 1);

   // delay_whole reduction modulo STORE_DEPTH
   localparam int RED_STEPS = $clog2(65535 / STORE_DEPTH + 1);
   localparam int RED_CNT_W = (RED_STEPS > 0) ? $clog2(RED_STEPS + 1) : 1;
   localparam int RED_SHIFT = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
   localparam logic [DELAY_W-1:0] RED_TOP =
      (RED_STEPS > 0) ? DELAY_W'(STORE_DEPTH << RED_SHIFT) : '0;
   localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(DELAY_WHOLE_RST % STORE_DEPTH);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_RDB    = 4'd2;
   localparam logic [3:0] S_RDA    = 4'd3;
   localparam logic [3:0] S_DIFF   = 4'd4;
   localparam logic [3:0] S_MULF   = 4'd5;
   localparam logic [3:0] S_INTERP = 4'd6;
   localparam logic [3:0] S_MULG   = 4'd7;
   localparam logic [3:0] S_ROUND  = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   logic [3:0]                state_ff, state_in;
   logic [AW-1:0]             clr_cnt_ff;
   logic [AW-1:0]             wp_ff, wp_in;
   logic [AW-1:0]             p_ff, p_in;
   logic [AW-1:0]             pm1;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic [FRAC_W-1:0]         frac_ff;
   logic signed [GAIN_W-1:0]  gain_ff;
   logic [DELAY_W-1:0]        red_val_ff;
   logic [DELAY_W-1:0]        red_sub_ff;
   logic [RED_CNT_W-1:0]      red_cnt_ff;
   logic                      rsp_tvalid_ff;
   logic signed [SAMPLE_W-1:0] rsp_tdata_ff;
   logic [SAMPLE_W-1:0]       rd_data_ff;

   logic [31:0]               dly_ext;
   logic [AW-1:0]             dmod;
   logic [AW:0]               p_diff, p_wrap;
   logic                      req_acc;
   logic                      out_free;
   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic [SAMPLE_W-1:0]       mem_wdata;
   logic [AW-1:0]             rd_addr;
   logic signed [SAMPLE_W-1:0] sum;
   fdl_ctl_type               ctl;

   logic [SAMPLE_W-1:0]       mem [STORE_DEPTH];

   // ---------------- registers and delay reduction ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff    <= '0;
         gain_ff    <= '0;
         red_val_ff <= DELAY_RST;
         red_sub_ff <= '0;
         red_cnt_ff <= '0;
      end else begin
         if (csr_wen && csr_index == CSR_DELAY_WHOLE) begin
            red_val_ff <= csr_wdata[DELAY_W-1:0];
            red_sub_ff <= RED_TOP;
            red_cnt_ff <= RED_CNT_W'(RED_STEPS);
         end else if (red_cnt_ff != '0) begin
            if (red_val_ff >= red_sub_ff) begin
               red_val_ff <= red_val_ff - red_sub_ff;
            end
            red_sub_ff <= red_sub_ff >> 1;
            red_cnt_ff <= red_cnt_ff - 1'b1;
         end
         if (csr_wen && csr_index == CSR_DELAY_FRAC) begin
            frac_ff <= csr_wdata[FRAC_W-1:0];
         end
         if (csr_wen && csr_index == CSR_FEEDBACK_GAIN) begin
            gain_ff <= $signed(csr_wdata[GAIN_W-1:0]);
         end
      end
   end

   assign dly_ext = 32'(red_val_ff);
   assign dmod    = dly_ext[AW-1:0];

   // read position trails the write position, wrapping at the store depth
   assign p_diff = {1'b0, wp_ff} - {1'b0, dmod};
   assign p_wrap = p_diff[AW] ? p_diff + DEPTH_X : p_diff;
   assign p_in   = p_wrap[AW-1:0];
   assign pm1    = (p_ff == '0) ? LAST_SLOT : p_ff - 1'b1;

   // ---------------- sequencer ----------------
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && (red_cnt_ff == '0);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      wp_in    = wp_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_cnt_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               state_in = S_RDB;
            end
         end
         S_RDB:    state_in = S_RDA;
         S_RDA:    state_in = S_DIFF;
         S_DIFF:   state_in = S_MULF;
         S_MULF:   state_in = S_INTERP;
         S_INTERP: state_in = S_MULG;
         S_MULG:   state_in = S_ROUND;
         S_ROUND:  state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
               wp_in    = (wp_ff == LAST_SLOT) ? '0 : wp_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl.busy = (state_ff != S_IDLE) && (state_ff != S_CLEAR);
      unique case (state_ff)
         S_RDA:    ctl.op = OP_LOAD_B;
         S_DIFF:   ctl.op = OP_DIFF;
         S_MULF:   ctl.op = OP_MULF;
         S_INTERP: ctl.op = OP_INTERP;
         S_MULG:   ctl.op = OP_MULG;
         S_ROUND:  ctl.op = OP_ROUND;
         default:  ctl.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         wp_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         if (state_ff == S_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (state_ff == S_OUT && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         x_ff <= req_tdata;
         p_ff <= p_in;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_tdata_ff <= sum;
      end
   end

   // ---------------- sample store ----------------
   assign mem_we    = (state_ff == S_CLEAR) || (state_ff == S_OUT && out_free);
   assign mem_waddr = (state_ff == S_CLEAR) ? clr_cnt_ff : wp_ff;
   assign mem_wdata = (state_ff == S_CLEAR) ? '0 : sum;
   assign rd_addr   = (state_ff == S_RDB) ? p_ff : pm1;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   fdl_arith u_arith (
      .clock   (clock),
      .ctl     (ctl),
      .rd_data (rd_data_ff),
      .frac    (frac_ff),
      .gain    (gain_ff),
      .sample  (x_ff),
      .sum     (sum)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------- assertions ----------------
   `ASSERT_CLK(a_rsp_from_out, clock, reset, $rose(rsp_tvalid_ff) |-> $past(state_ff) == S_OUT, "result raised outside the output step")
   `ASSERT_CLK(a_wp_with_result, clock, reset, (!$past(reset) && !$stable(wp_ff)) |-> rsp_tvalid_ff, "write position moved without a result")
   `ASSERT_CLK(a_no_accept_busy, clock, reset, (ctl.busy || red_cnt_ff != '0) |-> !req_tready, "input taken while a sample or delay update is in flight")
   `ASSERT_ALWAYS(a_clear_no_ready, clock, (state_ff == S_CLEAR) |-> !req_tready, "input taken during store clearing")

endmodule

`default_nettype wire
